FILE: hw/rtl/spbu_pkg.sv
// Shared types and constants for the serpentine priority bit unpermute block.
`default_nettype none

package spbu_pkg;

  // Input kinds carried in s_tuser
  localparam logic [1:0] OP_MAP    = 2'd0;
  localparam logic [1:0] OP_MATRIX = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Field widths
  localparam int OP_W    = 2;
  localparam int BIT_W   = 13;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 10;

  // Input tdata layout, lowest bit first
  localparam int SRC_LO  = 0;
  localparam int DST_LO  = SRC_LO + BIT_W;
  localparam int ROW_LO  = DST_LO + BIT_W;
  localparam int COL_LO  = ROW_LO + ROW_W;
  localparam int MBYTE_LO = COL_LO + COL_W;
  localparam int IDX_LO  = MBYTE_LO + BYTE_W;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 24;

  // Destination table
  localparam int TABLE_DEPTH = 7168;
  localparam int TBL_AW      = 13;
  localparam int TBL_DW      = BIT_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [IDX_W-1:0] INPUT_SIZE_RESET = 10'd896;

  typedef enum logic [1:0] {
    CMD_MAP,
    CMD_MAT,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [BIT_W-1:0]        dst;
    logic [BIT_W-1:0]        src;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic [BYTE_W-1:0]       mbyte;
    logic [IDX_W-1:0]        idx;
    logic                    oor;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_GATHER,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/serpentine_priority_bit_unpermute.sv
// Top level: input_size register, front end, command queue and back end.
// An item kept by the front end is queued the cycle it is accepted; a read at the queue head
// starts once the back end is idle and goes valid after its eight lookups pass the four-stage
// gather and the DONE state. Map and matrix writes retire one per cycle while the back end is
// in its run state; a read holds the back end through the gather and the result hand-off,
// longer if m_tready is low. Reset: table swept clear with s_tready low; input_size is 896.
`default_nettype none

module serpentine_priority_bit_unpermute import spbu_pkg::*; #(
  parameter int MATRIX_ROWS = 14,
  parameter int ROW_SYMBOLS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // source_bit, dest_bit, matrix_row, matrix_byte_col, matrix_byte, read_index, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // op
  input  wire logic [OP_W-1:0]       s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // out_index, out_byte, zero pad
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // out_of_range
  output logic                       m_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [IDX_W-1:0]      cfg_data
);

  logic [IDX_W-1:0]  input_size;
  logic              clearing;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  cmd_t              q_in;
  cmd_t              q_out;
  logic [IDX_W-1:0]  out_index;
  logic [BYTE_W-1:0] out_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_size <= INPUT_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      input_size <= cfg_data;
    end
  end

  spbu_front #(
    .MATRIX_ROWS (MATRIX_ROWS),
    .ROW_SYMBOLS (ROW_SYMBOLS)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .input_size (input_size),
    .clearing   (clearing),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  spbu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  spbu_back #(
    .MATRIX_ROWS (MATRIX_ROWS),
    .ROW_SYMBOLS (ROW_SYMBOLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .input_size (input_size),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_index  (out_index),
    .out_byte   (out_byte),
    .out_oor    (m_tuser)
  );

  assign m_tdata = {{(OUT_DATA_W - IDX_W - BYTE_W){1'b0}}, out_byte, out_index};

endmodule

`default_nettype wire

FILE: hw/rtl/spbu_front.sv
// Front end: accepts input items, range-checks and classifies them into queue commands.
`default_nettype none

module spbu_front import spbu_pkg::*; #(
  parameter int MATRIX_ROWS = 14,
  parameter int ROW_SYMBOLS = 32
) (
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // source_bit, dest_bit, matrix_row, matrix_byte_col, matrix_byte, read_index, zero pad
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  // op
  input  wire logic [OP_W-1:0]      s_tuser,
  input  wire logic [IDX_W-1:0]     input_size,
  input  wire logic                 clearing,
  input  wire logic                 q_full,
  output logic                      q_push,
  output cmd_t                      q_data
);

  localparam int ROW_BYTES = 2 * ROW_SYMBOLS;

  logic [BIT_W-1:0]  src;
  logic [BIT_W-1:0]  dst;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [BYTE_W-1:0] mbyte;
  logic [IDX_W-1:0]  idx;
  logic              keep;

  assign src   = s_tdata[SRC_LO +: BIT_W];
  assign dst   = s_tdata[DST_LO +: BIT_W];
  assign row   = s_tdata[ROW_LO +: ROW_W];
  assign col   = s_tdata[COL_LO +: COL_W];
  assign mbyte = s_tdata[MBYTE_LO +: BYTE_W];
  assign idx   = s_tdata[IDX_LO +: IDX_W];

  always_comb begin
    q_data.kind  = CMD_READ;
    q_data.dst   = dst;
    q_data.src   = src;
    q_data.row   = row;
    q_data.col   = col;
    q_data.mbyte = mbyte;
    q_data.idx   = idx;
    q_data.oor   = (idx >= input_size);
    keep         = 1'b0;
    unique case (s_tuser)
      OP_MAP: begin
        q_data.kind = CMD_MAP;
        keep        = (32'(dst) < 32'(TABLE_DEPTH));
      end
      OP_MATRIX: begin
        q_data.kind = CMD_MAT;
        keep        = (32'(row) < 32'(MATRIX_ROWS)) && (32'(col) < 32'(ROW_BYTES));
      end
      OP_READ: begin
        q_data.kind = CMD_READ;
        keep        = 1'b1;
      end
      default: begin
        // unused kind: drop
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

FILE: hw/rtl/spbu_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module spbu_queue import spbu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  cmd_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: hw/rtl/spbu_back.sv
// Back end: table and matrix memories, bit gather pipeline and result register.
`default_nettype none

module spbu_back import spbu_pkg::*; #(
  parameter int MATRIX_ROWS = 14,
  parameter int ROW_SYMBOLS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IDX_W-1:0]  input_size,
  input  wire logic              q_empty,
  input  cmd_t                   q_data,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       out_index,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_oor
);

  localparam int ROW_BYTES    = 2 * ROW_SYMBOLS;
  localparam int MATRIX_BYTES = MATRIX_ROWS * ROW_BYTES;
  localparam int MAW          = $clog2(MATRIX_BYTES);
  localparam int RW           = $clog2(MATRIX_ROWS);
  localparam int CW           = $clog2(ROW_BYTES);
  // byte position / ROW_BYTES as a reciprocal multiply, exact for 10-bit positions
  localparam int SHIFT        = IDX_W + CW;
  localparam int RECIP        = ((1 << SHIFT) + ROW_BYTES - 1) / ROW_BYTES;
  localparam int RCW          = $clog2(RECIP + 1);
  localparam int PW           = IDX_W + RCW;

  back_state_t state;
  back_state_t state_next;

  logic [TBL_DW-1:0] tbl_mem [TABLE_DEPTH];
  logic [BYTE_W-1:0] mat_mem [MATRIX_BYTES];

  logic [TBL_AW-1:0] clr_addr;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_DW-1:0] tbl_wdata;
  logic              mat_we;
  logic [MAW-1:0]    mat_waddr;
  logic [31:0]       mat_wfull;
  logic              start_read;
  logic              load_out;

  logic [IDX_W-1:0]  rd_idx;
  logic              rd_oor;
  logic [3:0]        issue_cnt;
  logic [2:0]        done_cnt;
  logic              issuing;
  logic [TBL_AW-1:0] dst;
  logic              dst_ok;
  logic [TBL_AW-1:0] tbl_raddr;

  // stage 1: table word
  logic              v1;
  logic              ok1;
  logic [TBL_DW-1:0] tbl_q;
  logic [IDX_W-1:0]  pos1;
  logic              use1;
  // stage 2: reciprocal product
  logic              v2;
  logic              use2;
  logic [PW-1:0]     prod2;
  logic [IDX_W-1:0]  pos2;
  logic [2:0]        bit2;
  logic [IDX_W-1:0]  order2;
  logic [31:0]       col_full;
  logic [31:0]       row_full;
  // stage 3: row and column
  logic              v3;
  logic              use3;
  logic [RW-1:0]     row3;
  logic [CW-1:0]     col3;
  logic [2:0]        bit3;
  logic [31:0]       addr_full;
  logic [MAW-1:0]    mat_raddr;
  // stage 4: matrix byte
  logic              v4;
  logic              use4;
  logic [2:0]        bit4;
  logic [BYTE_W-1:0] mat_q;
  logic              bit_val;
  logic [BYTE_W-1:0] acc;

  assign clearing = (state == BK_CLEAR);

  assign mat_wfull = 32'(q_data.row) * 32'(ROW_BYTES) + 32'(q_data.col);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    tbl_we     = 1'b0;
    tbl_waddr  = q_data.dst;
    tbl_wdata  = {1'b1, q_data.src};
    mat_we     = 1'b0;
    mat_waddr  = MAW'(mat_wfull);
    start_read = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_addr;
        tbl_wdata = '0;
        if (clr_addr == TBL_AW'(TABLE_DEPTH - 1)) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_data.kind)
            CMD_MAP:  tbl_we = 1'b1;
            CMD_MAT:  mat_we = 1'b1;
            CMD_READ: begin
              start_read = 1'b1;
              state_next = BK_GATHER;
            end
            default: ;
          endcase
        end
      end
      BK_GATHER: begin
        if (v4 && done_cnt == 3'd7) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        // hold the byte until the result register frees up
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= q_data.mbyte;
    end
    mat_q <= mat_mem[mat_raddr];
  end

  // issue one destination bit per cycle
  assign issuing   = (state == BK_GATHER) && !issue_cnt[3];
  assign dst       = {rd_idx, issue_cnt[2:0]};
  assign dst_ok    = (32'(dst) < 32'(TABLE_DEPTH));
  assign tbl_raddr = dst_ok ? dst : '0;

  always_ff @(posedge clk) begin
    if (start_read) begin
      rd_idx <= q_data.idx;
      rd_oor <= q_data.oor;
    end
    ok1 <= dst_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      done_cnt  <= '0;
    end else if (start_read) begin
      issue_cnt <= '0;
      done_cnt  <= '0;
    end else begin
      if (issuing) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (v4) begin
        done_cnt <= done_cnt + 1'b1;
      end
    end
  end

  // stage 1: decode the table word
  assign pos1 = tbl_q[BIT_W-1:3];
  assign use1 = tbl_q[TBL_DW-1] && ok1 && !rd_oor && (pos1 < input_size) &&
                (32'(pos1) < 32'(MATRIX_BYTES));

  // stage 2: split the stream byte number into serpentine order, row and column
  assign order2   = IDX_W'(prod2 >> SHIFT);
  assign col_full = 32'(pos2) - 32'(order2) * 32'(ROW_BYTES);
  assign row_full = order2[0] ? 32'(order2[IDX_W-1:1]) :
                    32'(MATRIX_ROWS - 1) - 32'(order2[IDX_W-1:1]);

  // stage 3: matrix address, unused lanes read entry zero
  assign addr_full = 32'(row3) * 32'(ROW_BYTES) + 32'(col3);
  assign mat_raddr = use3 ? MAW'(addr_full) : '0;

  // stage 4: pick the bit, MSB first
  assign bit_val = use4 && mat_q[3'd7 - bit4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    prod2 <= PW'(pos1) * PW'(RECIP);
    pos2  <= pos1;
    bit2  <= tbl_q[2:0];
    use2  <= use1;
    row3  <= RW'(row_full);
    col3  <= CW'(col_full);
    bit3  <= bit2;
    use3  <= use2;
    bit4  <= bit3;
    use4  <= use3;
    if (v4) begin
      acc <= {acc[BYTE_W-2:0], bit_val};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index <= rd_idx;
      out_byte  <= acc;
      out_oor   <= rd_oor;
    end
  end

  a_pop_in_run: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_RUN) && !q_empty)
    else $error("command taken outside run state");
  a_no_write_gather: assert property (@(posedge clk) disable iff (rst)
    (state == BK_GATHER) |-> !tbl_we && !mat_we)
    else $error("memory write during bit gather");
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_oor) |-> (out_byte == '0))
    else $error("out of range result carries data");

endmodule

`default_nettype wire

FILE: sim/spbu_checker.sv
`timescale 1ns / 100ps
// Checker for the bit unpermute block: mirrors its tables, predicts read items, compares.
module spbu_checker import spbu_pkg::*; #(
  parameter int MATRIX_ROWS = 14,
  parameter int ROW_SYMBOLS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  // source_bit, dest_bit, matrix_row, matrix_byte_col, matrix_byte, read_index, zero pad
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  // op
  input  wire logic [OP_W-1:0]      s_tuser,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  // out_index, out_byte, zero pad
  input  wire logic [OUT_DATA_W-1:0] m_tdata,
  // out_of_range
  input  wire logic                 m_tuser,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [IDX_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int ROW_BYTES    = 2 * ROW_SYMBOLS;
  localparam int MATRIX_BYTES = MATRIX_ROWS * ROW_BYTES;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] value;
    logic              oor;
  } restored_t;

  logic [BIT_W-1:0]       source_of [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] mapped;
  logic [BYTE_W-1:0]      matrix [MATRIX_BYTES];
  logic [IDX_W-1:0]       payload_size;
  restored_t              restored_due [$];

  // Byte pos of the serpentine stream; zero past the payload or the matrix.
  function automatic logic [BYTE_W-1:0] stream_byte_at(int unsigned pos);
    int unsigned order;
    int unsigned row;
    if (pos >= payload_size || pos >= MATRIX_BYTES) return '0;
    order = pos / ROW_BYTES;
    // even slots walk up from the bottom row, odd slots down from the top
    row = order[0] ? order / 2 : MATRIX_ROWS - 1 - order / 2;
    return matrix[row * ROW_BYTES + pos % ROW_BYTES];
  endfunction

  function automatic restored_t restore_byte(logic [IDX_W-1:0] idx);
    restored_t         r;
    int unsigned       dst;
    int unsigned       src;
    logic [BYTE_W-1:0] sbyte;
    r.index = idx;
    r.value = '0;
    r.oor   = (idx >= payload_size);
    if (!r.oor) begin
      for (int k = 0; k < 8; k++) begin
        dst = 8 * int'(idx) + k;
        if (dst < TABLE_DEPTH && mapped[dst]) begin
          src = 32'(source_of[dst]);
          sbyte = stream_byte_at(src >> 3);
          r.value[7 - k] = sbyte[7 - (src % 8)];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    restored_t        got;
    restored_t        want;
    logic [BIT_W-1:0] dst;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    if (rst) begin
      mapped = '0;
      restored_due.delete();
      payload_size = INPUT_SIZE_RESET;
      mismatches = 0;
    end else begin
      // retire the oldest prediction before queuing any new one
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[0 +: IDX_W];
        got.value = m_tdata[IDX_W +: BYTE_W];
        got.oor   = m_tuser;
        if (restored_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("ERROR unexpected result: idx %0d byte %02h oor %0b",
                     got.index, got.value, got.oor);
          mismatches++;
        end else begin
          want = restored_due.pop_front();
          if (got.index !== want.index || got.value !== want.value || got.oor !== want.oor) begin
            if (mismatches < MAX_REPORTS)
              $display("ERROR read result: expected idx %0d byte %02h oor %0b, got idx %0d byte %02h oor %0b",
                       want.index, want.value, want.oor, got.index, got.value, got.oor);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) payload_size = cfg_data;
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_MAP: begin
            dst = s_tdata[DST_LO +: BIT_W];
            if (dst < TABLE_DEPTH) begin
              source_of[dst] = s_tdata[SRC_LO +: BIT_W];
              mapped[dst] = 1'b1;
            end
          end
          OP_MATRIX: begin
            row = s_tdata[ROW_LO +: ROW_W];
            col = s_tdata[COL_LO +: COL_W];
            if (row < MATRIX_ROWS && col < ROW_BYTES)
              matrix[row * ROW_BYTES + col] = s_tdata[MBYTE_LO +: BYTE_W];
          end
          OP_READ: restored_due.insert(restored_due.size(),
                                       restore_byte(s_tdata[IDX_LO +: IDX_W]));
          default: ;
        endcase
      end
    end
    outstanding = restored_due.size();
  end

endmodule

FILE: sim/serpentine_priority_bit_unpermute_tb.sv
`timescale 1ns / 100ps
// Testbench top for the bit unpermute block: stimulus, stalls, watchdog and verdict.
module serpentine_priority_bit_unpermute_tb;
  import spbu_pkg::*;

  localparam int MATRIX_ROWS  = 14;
  localparam int ROW_SYMBOLS  = 32;
  localparam int ROW_BYTES    = 2 * ROW_SYMBOLS;
  localparam int MATRIX_BYTES = MATRIX_ROWS * ROW_BYTES;
  localparam int QUIET_LIMIT  = 25000;
  localparam int SETTLE       = 40;
  localparam int PHASE_ITEMS  = 130;
  localparam int PHASES       = 6;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_data = '0;

  int fail_count;
  int outstanding;
  int send_idle = 16;
  int recv_idle = 78;
  int quiet_cycles = 0;
  int payload_bytes = MATRIX_BYTES;

  always #4 clk = ~clk;

  serpentine_priority_bit_unpermute #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .ROW_SYMBOLS(ROW_SYMBOLS)
  ) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  spbu_checker #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .ROW_SYMBOLS(ROW_SYMBOLS)
  ) u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(fail_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // The clearing sweep after reset is the longest legal quiet stretch.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] filler_bits();
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom(), $urandom()});
    d[IN_DATA_W-1:IDX_LO+IDX_W] = '0;
    return d;
  endfunction

  function automatic int payload_span();
    return (payload_bytes < MATRIX_BYTES) ? payload_bytes : MATRIX_BYTES;
  endfunction

  function automatic int pick_source();
    if ($urandom_range(9) == 0) return $urandom_range(8191);
    return $urandom_range(payload_span() * 8 - 1);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_map(input int src, input int dst);
    logic [IN_DATA_W-1:0] d;
    d = filler_bits();
    d[SRC_LO +: BIT_W] = BIT_W'(src);
    d[DST_LO +: BIT_W] = BIT_W'(dst);
    send_item(OP_MAP, d);
  endtask

  task automatic send_matrix(input int row, input int col, input int value);
    logic [IN_DATA_W-1:0] d;
    d = filler_bits();
    d[ROW_LO +: ROW_W]    = ROW_W'(row);
    d[COL_LO +: COL_W]    = COL_W'(col);
    d[MBYTE_LO +: BYTE_W] = BYTE_W'(value);
    send_item(OP_MATRIX, d);
  endtask

  task automatic send_read(input int idx);
    logic [IN_DATA_W-1:0] d;
    d = filler_bits();
    d[IDX_LO +: IDX_W] = IDX_W'(idx);
    send_item(OP_READ, d);
  endtask

  task automatic write_size(input int size);
    cfg_valid <= 1'b1;
    cfg_data  <= IDX_W'(size);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    payload_bytes = size;
  endtask

  // Hold the sender until every read is answered, then let queued writes retire.
  task automatic drain_reads();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sizes [PHASES];
    int sent;
    int sel;
    int byte_idx;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_size(MATRIX_BYTES);

    // fill every matrix byte so no read ever touches an unwritten one
    for (int r = 0; r < MATRIX_ROWS; r++)
      for (int c = 0; c < ROW_BYTES; c++)
        send_matrix(r, c, $urandom_range(255));

    send_map(0, 0);
    send_map(MATRIX_BYTES * 8 - 1, 1);
    send_map(8191, 2);
    send_map(5, 3);
    send_map(6, 3);
    send_map(ROW_BYTES * 8, 4);
    send_map(2 * ROW_BYTES * 8 + 7, 5);
    send_map(100, TABLE_DEPTH - 1);
    send_map(1, 8191);
    send_map(9, TABLE_DEPTH);
    send_read(0);
    send_read(MATRIX_BYTES - 1);
    send_read(MATRIX_BYTES);
    send_read(1023);
    send_matrix(15, 0, 8'hA5);
    send_matrix(MATRIX_ROWS, ROW_BYTES - 1, 8'h5A);
    send_matrix(0, ROW_BYTES - 1, 8'hFF);
    send_matrix(MATRIX_ROWS - 1, 0, 8'h00);
    send_item(OP_SPARE, {2'b00, {(IN_DATA_W - 2){1'b1}}});
    send_read(0);

    sizes = '{1, 1023, $urandom_range(2, 895), MATRIX_BYTES, $urandom_range(2, 64),
              $urandom_range(1, 896)};
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_reads();
      send_idle = (ph < 2) ? 16 : (ph < 4) ? 78 : 0;
      recv_idle = (ph < 2) ? 78 : (ph < 4) ? 16 : 0;
      write_size(sizes[ph]);
      sent = 0;
      while (sent < PHASES * 0 + PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 45) begin
          // map one output byte's bits, leaving some unmapped, then read it back
          byte_idx = ($urandom_range(9) == 0) ? $urandom_range(1023)
                                               : $urandom_range(payload_span() - 1);
          for (int k = 0; k < 8; k++) begin
            if ($urandom_range(7) != 0) begin
              send_map(pick_source(), byte_idx * 8 + k);
              sent++;
            end
          end
          send_read(byte_idx);
          sent++;
        end else if (sel < 65) begin
          send_read(($urandom_range(3) == 0) ? $urandom_range(1023)
                                             : $urandom_range(payload_span() - 1));
          sent++;
        end else if (sel < 80) begin
          send_map($urandom_range(8191), $urandom_range(8191));
          sent++;
        end else if (sel < 95) begin
          send_matrix($urandom_range(15), $urandom_range(63), $urandom_range(255));
          sent++;
        end else begin
          send_item(OP_SPARE, filler_bits());
        end
        if ($urandom_range(199) == 0) drain_reads();
      end
    end
    drain_reads();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
